// ----- rtl/lepseq_pkg.sv -----
`default_nettype none

package lepseq_pkg;

    // counter width of the sequencer, default for the top level parameter
    localparam int LEPSEQ_COUNT_WIDTH = 8;

    // fixed field widths of the ports
    localparam int CFG_DATA_WIDTH  = 8;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int STEP_WIDTH      = 8;
    localparam int SCREEN_WIDTH    = 8;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_EFFECT_MODE         = 3'd0,
        CFG_APPEAR_LAST_STEP    = 3'd1,
        CFG_HOLD_TICKS          = 3'd2,
        CFG_DISAPPEAR_LAST_STEP = 3'd3,
        CFG_SCREEN_LAST         = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_HOLD_PER_SCREEN = 2'd0,
        MODE_FULL_CYCLE      = 2'd1,
        MODE_ROLL_UP         = 2'd2,
        MODE_ROLL_DOWN       = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        PH_NONE      = 3'd0,
        PH_APPEAR    = 3'd1,
        PH_HOLD      = 3'd2,
        PH_DISAPPEAR = 3'd3,
        PH_ROLL      = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ACT_IDLE      = 3'd0,
        ACT_CLEAR     = 3'd1,
        ACT_APPEAR    = 3'd2,
        ACT_ROLL      = 3'd3,
        ACT_DISAPPEAR = 3'd4,
        ACT_COPY      = 3'd5
    } action_t;

    typedef struct packed {
        mode_t                     effect_mode;
        logic [CFG_DATA_WIDTH-1:0] appear_last_step;
        logic [CFG_DATA_WIDTH-1:0] hold_ticks;
        logic [CFG_DATA_WIDTH-1:0] disappear_last_step;
        logic [CFG_DATA_WIDTH-1:0] screen_last;
    } cfg_t;

    typedef struct packed {
        action_t                 action;
        logic [STEP_WIDTH-1:0]   step_index;
        logic [SCREEN_WIDTH-1:0] screen_index;
        logic                    load_current;
        logic                    load_next;
        logic                    load_last;
        logic                    action_done;
        phase_t                  phase;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/led_effect_phase_sequencer_core.sv -----
`default_nettype none

// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+------------------------------------------
// input     | in        | in_valid / in_ready    | frame_tick
// result    | out       | out_valid / out_ready  | action, step_index, screen_index,
//           |           |                        | load_current, load_next, load_last,
//           |           |                        | action_done, phase
// config    | in        | cfg_wr_en (no wait)    | cfg_index, cfg_data
//
// one beat per cycle sustained while out_ready holds; a beat passes the input register, then the result register
// stage one is the input register, stage two is the phase step logic feeding the
// result register; sequencer state updates when a beat moves from stage one to two
// reset clears config, sequencer state and both valid flags
// a stalled result holds its register; the input register still takes one more beat,
// then in_ready drops until out_ready frees the result register

module led_effect_phase_sequencer_core
    import lepseq_pkg::*;
#(
    parameter int COUNT_WIDTH = LEPSEQ_COUNT_WIDTH
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,

    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic                       frame_tick,

    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [2:0]                      action,
    output logic [STEP_WIDTH-1:0]           step_index,
    output logic [SCREEN_WIDTH-1:0]         screen_index,
    output logic                            load_current,
    output logic                            load_next,
    output logic                            load_last,
    output logic                            action_done,
    output logic [2:0]                      phase
);

    cfg_t    cfg;
    result_t step_result;
    result_t result_reg;

    // input register
    logic in_valid_reg;
    logic tick_reg;
    // result register valid
    logic out_valid_reg;
    // stage one beat moves into the result register
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    lepseq_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lepseq_step #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step_en    (advance),
        .frame_tick (tick_reg),
        .result     (step_result)
    );

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg <= frame_tick;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign action       = result_reg.action;
    assign step_index   = result_reg.step_index;
    assign screen_index = result_reg.screen_index;
    assign load_current = result_reg.load_current;
    assign load_next    = result_reg.load_next;
    assign load_last    = result_reg.load_last;
    assign action_done  = result_reg.action_done;
    assign phase        = result_reg.phase;

    // end of action always lands back in phase none
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action_done) |-> (phase == PH_NONE))
        else $error("action_done with phase not none");

    // step index only carries a value on step commands
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && step_index != '0) |->
            (action == ACT_APPEAR || action == ACT_ROLL || action == ACT_DISAPPEAR))
        else $error("step index set on a non-step command");

    // next and last buffers never load together, and each comes with a current load
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (load_next || load_last)) |-> (load_current && !(load_next && load_last)))
        else $error("bad screen load combination");

    // clearing the next frame always starts a screen with a current load in appear
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && action == ACT_CLEAR) |-> (load_current && phase == PH_APPEAR))
        else $error("clear without current load or appear");

    // a stalled result is never overwritten by the step stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid_reg && $stable(result_reg))
        else $error("result register changed under stall");

endmodule

`default_nettype wire

// ----- rtl/lepseq_cfg_regs.sv -----
`default_nettype none

module lepseq_cfg_regs
    import lepseq_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_EFFECT_MODE:         cfg_reg.effect_mode <= mode_t'(cfg_data[1:0]);
                CFG_APPEAR_LAST_STEP:    cfg_reg.appear_last_step <= cfg_data;
                CFG_HOLD_TICKS:          cfg_reg.hold_ticks <= cfg_data;
                CFG_DISAPPEAR_LAST_STEP: cfg_reg.disappear_last_step <= cfg_data;
                CFG_SCREEN_LAST:         cfg_reg.screen_last <= cfg_data;
                default:                 ;  // unused index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/lepseq_step.sv -----
`default_nettype none

module lepseq_step
    import lepseq_pkg::*;
#(
    parameter int COUNT_WIDTH = LEPSEQ_COUNT_WIDTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic step_en,
    input  wire logic frame_tick,
    output result_t   result
);

    // step counters carry one extra bit so they can pass the last step
    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH:0]   app_cnt_reg, app_cnt_next;
    logic [COUNT_WIDTH:0]   dis_cnt_reg, dis_cnt_next;
    logic [COUNT_WIDTH-1:0] hold_cnt_reg, hold_cnt_next;
    logic [COUNT_WIDTH-1:0] scr_cnt_reg, scr_cnt_next;

    logic [COUNT_WIDTH:0]   app_last, dis_last;
    logic [COUNT_WIDTH-1:0] hold_lim, scr_last;
    logic [COUNT_WIDTH:0]   app_inc, dis_inc;
    logic [COUNT_WIDTH-1:0] hold_inc;
    logic                   app_in, app_end, dis_in, dis_end, hold_in, hold_end;
    logic                   full_cycle, roll_down, roll_finished;

    assign app_last = {1'b0, COUNT_WIDTH'(cfg.appear_last_step)};
    assign dis_last = {1'b0, COUNT_WIDTH'(cfg.disappear_last_step)};
    assign hold_lim = COUNT_WIDTH'(cfg.hold_ticks);
    assign scr_last = COUNT_WIDTH'(cfg.screen_last);

    assign app_inc  = app_cnt_reg + 1'b1;
    assign dis_inc  = dis_cnt_reg + 1'b1;
    assign hold_inc = hold_cnt_reg + 1'b1;
    assign app_in   = (app_cnt_reg <= app_last);
    assign app_end  = (app_inc > app_last);
    assign dis_in   = (dis_cnt_reg <= dis_last);
    assign dis_end  = (dis_inc > dis_last);
    assign hold_in  = (hold_cnt_reg < hold_lim);
    assign hold_end = (hold_inc >= hold_lim);

    assign full_cycle    = (cfg.effect_mode == MODE_FULL_CYCLE);
    assign roll_down     = (cfg.effect_mode == MODE_ROLL_DOWN);
    assign roll_finished = roll_down ? (scr_cnt_reg == '0) : (scr_cnt_reg >= scr_last);

    always_comb
    begin
        phase_next    = phase_reg;
        app_cnt_next  = app_cnt_reg;
        dis_cnt_next  = dis_cnt_reg;
        hold_cnt_next = hold_cnt_reg;
        scr_cnt_next  = scr_cnt_reg;

        result              = '0;
        result.action       = ACT_IDLE;

        if (frame_tick)
        begin
            if (cfg.effect_mode inside {MODE_HOLD_PER_SCREEN, MODE_FULL_CYCLE})
            begin
                case (phase_reg)
                    PH_NONE:
                    begin
                        app_cnt_next        = '0;
                        hold_cnt_next       = '0;
                        dis_cnt_next        = '0;
                        scr_cnt_next        = '0;
                        phase_next          = PH_APPEAR;
                        result.load_current = 1'b1;
                        result.action       = ACT_CLEAR;
                    end
                    PH_APPEAR:
                    begin
                        if (app_in)
                        begin
                            result.action     = ACT_APPEAR;
                            result.step_index = STEP_WIDTH'(app_cnt_reg);
                        end
                        app_cnt_next = app_end ? '0 : app_inc;
                        if (app_end)
                        begin
                            phase_next = (hold_lim != '0) ? PH_HOLD : PH_DISAPPEAR;
                        end
                    end
                    PH_HOLD:
                    begin
                        if (hold_in)
                        begin
                            result.action = ACT_COPY;
                        end
                        hold_cnt_next = hold_end ? '0 : hold_inc;
                        if (hold_end)
                        begin
                            if (full_cycle || scr_cnt_reg >= scr_last)
                            begin
                                phase_next = PH_DISAPPEAR;
                            end
                            else
                            begin
                                scr_cnt_next        = scr_cnt_reg + 1'b1;
                                result.load_current = 1'b1;
                                phase_next          = PH_APPEAR;
                            end
                        end
                    end
                    PH_DISAPPEAR:
                    begin
                        if (dis_in)
                        begin
                            result.action     = ACT_DISAPPEAR;
                            result.step_index = STEP_WIDTH'(dis_cnt_reg);
                        end
                        dis_cnt_next = dis_end ? '0 : dis_inc;
                        if (dis_end)
                        begin
                            if (!full_cycle || scr_cnt_reg >= scr_last)
                            begin
                                phase_next         = PH_NONE;
                                result.action_done = 1'b1;
                            end
                            else
                            begin
                                scr_cnt_next        = scr_cnt_reg + 1'b1;
                                result.load_current = 1'b1;
                                phase_next          = PH_APPEAR;
                            end
                        end
                    end
                    default: ;  // roll phase has no meaning here, tick is dropped
                endcase
            end
            else
            begin
                case (phase_reg)
                    PH_NONE:
                    begin
                        app_cnt_next        = '0;
                        scr_cnt_next        = roll_down ? scr_last : '0;
                        phase_next          = PH_APPEAR;
                        result.load_current = 1'b1;
                        result.load_last    = roll_down;
                        result.load_next    = !roll_down;
                        result.action       = ACT_CLEAR;
                    end
                    PH_APPEAR, PH_ROLL:
                    begin
                        if (app_in)
                        begin
                            result.action     = (phase_reg == PH_ROLL) ? ACT_ROLL : ACT_APPEAR;
                            result.step_index = STEP_WIDTH'(app_cnt_reg);
                        end
                        app_cnt_next = app_end ? '0 : app_inc;
                        if (app_end)
                        begin
                            if (phase_reg == PH_APPEAR)
                            begin
                                phase_next = PH_ROLL;
                            end
                            else if (roll_finished)
                            begin
                                phase_next         = PH_NONE;
                                result.action_done = 1'b1;
                            end
                            else
                            begin
                                scr_cnt_next        = roll_down ? scr_cnt_reg - 1'b1
                                                                : scr_cnt_reg + 1'b1;
                                result.load_current = 1'b1;
                                result.load_last    = roll_down;
                                result.load_next    = !roll_down;
                            end
                        end
                    end
                    default: ;  // hold and disappear have no meaning in roll modes
                endcase
            end
        end

        result.screen_index = SCREEN_WIDTH'(scr_cnt_next);
        result.phase        = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_NONE;
            app_cnt_reg  <= '0;
            dis_cnt_reg  <= '0;
            hold_cnt_reg <= '0;
            scr_cnt_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg    <= phase_next;
            app_cnt_reg  <= app_cnt_next;
            dis_cnt_reg  <= dis_cnt_next;
            hold_cnt_reg <= hold_cnt_next;
            scr_cnt_reg  <= scr_cnt_next;
        end
    end

endmodule

`default_nettype wire
